// ===== design/srsd_pkg.sv =====
// Package for the stitch record stream decoder.
// Types, escape codes and sizes shared by every design file; no dependencies.
`timescale 1ns / 1ps

package srsd_pkg;

	// Colour table size and derived widths
	localparam int MAX_COLORS = 128;
	localparam int TBL_AW     = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int CI_W       = 8;

	// Output queue size
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// Configuration register addresses
	localparam logic [1:0] ADDR_COLOR_COUNT = 2'd0;

	// Escape bytes of the stitch section
	localparam logic [7:0] ESC_BYTE     = 8'h80;
	localparam logic [7:0] ESC_TRIM     = 8'h01;
	localparam logic [7:0] ESC_JUMP_OFF = 8'h02;
	localparam logic [7:0] ESC_SKIP     = 8'h03;

	// Input word kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_STITCH = 1'b1;

	typedef enum logic [1:0] {
		REC_NORMAL = 2'd0,
		REC_JUMP   = 2'd1,
		REC_TRIM   = 2'd2,
		REC_STOP   = 2'd3
	} rec_kind_t;

	// Byte position within a pair or a trim escape
	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_SECOND = 3'd1,
		PH_LONG0  = 3'd2,
		PH_LONG1  = 3'd3,
		PH_LONG2  = 3'd4,
		PH_LONG3  = 3'd5
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  table_index;
		logic [31:0] stitch_count;
		logic [7:0]  data_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               last;
	} out_word_t;

	// Up to two records pushed into the output queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		out_word_t  a;
		out_word_t  b;
	} push_t;

endpackage

// ===== design/srsd_count_ram.sv =====
// Colour stitch count memory: one write port, one registered read port.
// Depends on srsd_pkg for the table size.
`timescale 1ns / 1ps

module srsd_count_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [srsd_pkg::TBL_AW-1:0] wr_addr,
	input  logic [31:0]               wr_data,
	input  logic [srsd_pkg::TBL_AW-1:0] rd_addr,
	output logic [31:0]               rd_data
);

	logic [31:0] mem [srsd_pkg::MAX_COLORS];
	logic [31:0] mem_rd_q;
	logic        byp_q;
	logic [31:0] byp_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, with the word written in the same cycle forwarded
	always_ff @(posedge clk) begin
		mem_rd_q   <= mem[rd_addr];
		byp_q      <= wr_en && (wr_addr == rd_addr);
		byp_data_q <= wr_data;
	end

	assign rd_data = byp_q ? byp_data_q : mem_rd_q;

endmodule

// ===== design/srsd_decode.sv =====
// Byte stream decode: pair/escape state, colour change tracking and record build.
// Depends on srsd_pkg and srsd_count_ram.
`timescale 1ns / 1ps

module srsd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  srsd_pkg::in_word_t item,
	input  logic [6:0]        color_count,
	output srsd_pkg::push_t   push
);

	srsd_pkg::phase_t       phase_q, phase_n;
	logic [7:0]             held_q, held_n;
	logic [23:0]            lb_q, lb_n;
	logic                   jump_q, jump_n;
	logic [srsd_pkg::CI_W-1:0] ci_q, ci_n;
	logic [31:0]            since_q, since_n;

	logic [31:0]            cur_count;
	logic                   wr_en;
	logic                   stop;
	logic                   stitch;
	logic [1:0]             inc;
	logic [31:0]            base;
	logic [32:0]            sum;
	logic [7:0]             b;
	srsd_pkg::out_word_t    stitch_rec;
	srsd_pkg::out_word_t    stop_rec;

	srsd_count_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (srsd_pkg::TBL_AW'(item.table_index)),
		.wr_data (item.stitch_count),
		.rd_addr (ci_n[srsd_pkg::TBL_AW-1:0]),
		.rd_data (cur_count)
	);

	assign b   = item.data_byte;
	assign sum = {1'b0, base} + 33'(inc);

	// Record templates
	always_comb begin
		stop_rec             = '0;
		stop_rec.record_kind = srsd_pkg::REC_STOP;
		stitch_rec.record_kind = jump_q ? srsd_pkg::REC_JUMP : srsd_pkg::REC_NORMAL;
		stitch_rec.delta_x   = {{8{held_q[7]}}, held_q};
		stitch_rec.delta_y   = {{8{b[7]}}, b};
		stitch_rec.last      = 1'b1;
	end

	// Next state and records for the word in the input register
	always_comb begin
		phase_n = phase_q;
		held_n  = held_q;
		lb_n    = lb_q;
		jump_n  = jump_q;
		ci_n    = ci_q;
		since_n = since_q;
		push    = '0;
		wr_en   = 1'b0;
		stop    = 1'b0;
		stitch  = 1'b0;
		inc     = 2'd0;
		base    = since_q;
		if (go) begin
			if (item.kind == srsd_pkg::KIND_LOAD) begin
				wr_en = (32'(item.table_index) < 32'(srsd_pkg::MAX_COLORS));
			end else begin
				case (phase_q)
					srsd_pkg::PH_SECOND: begin
						phase_n = srsd_pkg::PH_FIRST;
						stop = ({1'b0, ci_q} < {2'b00, color_count}) &&
						       (32'(ci_q) < 32'(srsd_pkg::MAX_COLORS)) &&
						       (since_q >= cur_count);
						if (stop) begin
							ci_n = ci_q + 1'b1;
							base = '0;
						end
						stitch = 1'b1;
						inc    = 2'd1;
						if (held_q == srsd_pkg::ESC_BYTE) begin
							if (b == srsd_pkg::ESC_SKIP) begin
								stitch = 1'b0;
							end else if (b == srsd_pkg::ESC_JUMP_OFF) begin
								jump_n = 1'b0;
								stitch = 1'b0;
							end else if (b == srsd_pkg::ESC_TRIM) begin
								inc     = 2'd3;
								jump_n  = 1'b1;
								lb_n    = '0;
								phase_n = srsd_pkg::PH_LONG0;
								stitch  = 1'b0;
							end else begin
								// unknown escape: plain stitch counted twice
								inc = 2'd2;
							end
						end
						since_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						if (stop && stitch) begin
							push.n = 2'd2;
							push.a = stop_rec;
							push.b = stitch_rec;
						end else if (stop) begin
							push.n      = 2'd1;
							push.a      = stop_rec;
							push.a.last = 1'b1;
						end else if (stitch) begin
							push.n = 2'd1;
							push.a = stitch_rec;
						end
					end
					srsd_pkg::PH_LONG0: begin
						lb_n    = {lb_q[15:0], b};
						phase_n = srsd_pkg::PH_LONG1;
					end
					srsd_pkg::PH_LONG1: begin
						lb_n    = {lb_q[15:0], b};
						phase_n = srsd_pkg::PH_LONG2;
					end
					srsd_pkg::PH_LONG2: begin
						lb_n    = {lb_q[15:0], b};
						phase_n = srsd_pkg::PH_LONG3;
					end
					srsd_pkg::PH_LONG3: begin
						push.n             = 2'd1;
						push.a.record_kind = srsd_pkg::REC_TRIM;
						push.a.delta_x     = lb_q[23:8];
						push.a.delta_y     = {lb_q[7:0], b};
						push.a.last        = 1'b1;
						phase_n            = srsd_pkg::PH_FIRST;
					end
					default: begin
						held_n  = b;
						phase_n = srsd_pkg::PH_SECOND;
					end
				endcase
			end
		end
	end

	// Stream state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srsd_pkg::PH_FIRST;
			held_q  <= '0;
			lb_q    <= '0;
			jump_q  <= 1'b0;
			ci_q    <= '0;
			since_q <= '0;
		end else begin
			phase_q <= phase_n;
			held_q  <= held_n;
			lb_q    <= lb_n;
			jump_q  <= jump_n;
			ci_q    <= ci_n;
			since_q <= since_n;
		end
	end

`ifndef ASSERT_OFF
	// the phase never reaches the unused codes
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == srsd_pkg::PH_FIRST) || (phase_q == srsd_pkg::PH_SECOND) ||
		(phase_q == srsd_pkg::PH_LONG0) || (phase_q == srsd_pkg::PH_LONG1) ||
		(phase_q == srsd_pkg::PH_LONG2) || (phase_q == srsd_pkg::PH_LONG3))
		else $error("byte phase left the valid range");
	// a trim escape always leaves jump mode on
	a_trim_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == srsd_pkg::PH_LONG0) |-> jump_q)
		else $error("trim escape without jump mode");
	// a colour stop resets the pair count
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ci_n != ci_q) |=> (since_q <= 32'd3))
		else $error("pair count not restarted after colour stop");
`endif

endmodule

// ===== design/srsd_rec_fifo.sv =====
// Output record queue: takes up to two records a cycle, gives one a cycle when not stalled.
// Depends on srsd_pkg for the record word and push group.
`timescale 1ns / 1ps

module srsd_rec_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  srsd_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output srsd_pkg::out_word_t out_data
);

	srsd_pkg::out_word_t          mem_q [srsd_pkg::FIFO_DEPTH];
	logic [srsd_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [srsd_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [srsd_pkg::FIFO_CW-1:0] cnt_q;
	logic                         pop;

	assign pop       = (cnt_q != '0) && !out_stall;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (cnt_q <= srsd_pkg::FIFO_CW'(srsd_pkg::FIFO_DEPTH - 2));

	// Record storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push.b;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + srsd_pkg::FIFO_AW'(push.n);
			rd_ptr_q <= rd_ptr_q + srsd_pkg::FIFO_AW'(pop);
			cnt_q    <= cnt_q + srsd_pkg::FIFO_CW'(push.n) - srsd_pkg::FIFO_CW'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= srsd_pkg::FIFO_CW'(srsd_pkg::FIFO_DEPTH))
		else $error("record queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("records pushed without room");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.a.record_kind == srsd_pkg::REC_STOP) && !push.a.last)
		else $error("two-record push not led by a colour stop");
`endif

endmodule

// ===== design/stitch_record_stream_decoder.sv =====
// A word accepted into the input register is decoded from there; its records
// go through the four-entry output queue and are offered on out_valid.
// Throughput: one input word per cycle while in_stall is low; a pair byte that
// closes a colour gives two records, taken one per cycle while out_stall is low.
// Reset (arst_n low, asynchronous): stream state, colour index and queue clear;
// the count table holds nothing defined until loaded.
`timescale 1ns / 1ps

module stitch_record_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	// input words
	input  logic                in_valid,
	output logic                in_stall,
	input  srsd_pkg::in_word_t  in_data,
	// result words
	output logic                out_valid,
	input  logic                out_stall,
	output srsd_pkg::out_word_t out_data,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic               s1_valid_q;
	srsd_pkg::in_word_t in_s1;
	logic               room;
	logic               go;
	logic [6:0]         color_count_q;
	srsd_pkg::push_t    push;

	// Register block
	assign pready = 1'b1;
	assign prdata = (paddr == srsd_pkg::ADDR_COLOR_COUNT) ? {25'd0, color_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr == srsd_pkg::ADDR_COLOR_COUNT)) begin
			color_count_q <= pwdata[6:0];
		end
	end

	// Input register
	assign go       = s1_valid_q && room;
	assign in_stall = s1_valid_q && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	srsd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.item        (in_s1),
		.color_count (color_count_q),
		.push        (push)
	);

	srsd_rec_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== test/stitch_record_stream_decoder_tb.sv =====
// Self-checking testbench for stitch_record_stream_decoder: directed table, then random words.
// Depends on srsd_pkg (word types, record kinds, escape bytes, register address) and the RTL.
`timescale 1ns / 1ps

module stitch_record_stream_decoder_tb;
	import srsd_pkg::*;

	localparam int LIMIT      = 3000;  // cycles with no handshake before giving up
	localparam int HOLD_WORDS = 200;   // length of the long receiver hold-off
	localparam int N_ROWS     = 28;

	// Expected outcome of one directed row; typed = 0 leaves it to the predictor
	typedef struct packed {
		logic       typed;
		logic [1:0] n;
		out_word_t  r0;
		out_word_t  r1;
	} row_exp_t;

	typedef struct packed {
		in_word_t w;
		row_exp_t e;
	} drow_t;

	localparam row_exp_t BY_MODEL = '0;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state
	logic [31:0] tbl_count [MAX_COLORS];
	logic [6:0]  ncolors;
	phase_t      ph;
	logic [7:0]  held;
	logic [23:0] long_acc;
	logic        jump_on;
	logic [7:0]  colour_idx;
	logic [31:0] pairs_since;

	out_word_t   pending_records [$];
	row_exp_t    row_exp_q [$];
	drow_t       dir_rows [N_ROWS];
	int          n_mismatch;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	bit          hold_off_req;
	int unsigned quiet_cycles;

	stitch_record_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] sx8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	// saturating add for the pair counter
	function automatic logic [31:0] since_plus(input logic [31:0] s, input logic [1:0] k);
		logic [32:0] t;
		t = {1'b0, s} + 33'(k);
		return t[32] ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	function automatic out_word_t make_rec(input rec_kind_t k, input logic [15:0] dx,
			input logic [15:0] dy, input logic lst);
		out_word_t r;
		r.record_kind = k;
		r.delta_x     = dx;
		r.delta_y     = dy;
		r.last        = lst;
		return r;
	endfunction

	// words: unused fields are random so every bit toggles
	function automatic in_word_t byte_w(input logic [7:0] b);
		in_word_t w;
		w.kind         = KIND_STITCH;
		w.table_index  = 7'($urandom);
		w.stitch_count = $urandom;
		w.data_byte    = b;
		return w;
	endfunction

	function automatic in_word_t load_w(input logic [6:0] idx, input logic [31:0] cnt);
		in_word_t w;
		w.kind         = KIND_LOAD;
		w.table_index  = idx;
		w.stitch_count = cnt;
		w.data_byte    = 8'($urandom);
		return w;
	endfunction

	function automatic row_exp_t exp_none();
		row_exp_t e;
		e       = '0;
		e.typed = 1'b1;
		return e;
	endfunction

	function automatic row_exp_t exp_one(input rec_kind_t k, input logic [15:0] dx,
			input logic [15:0] dy);
		row_exp_t e;
		e       = exp_none();
		e.n     = 2'd1;
		e.r0    = make_rec(k, dx, dy, 1'b1);
		return e;
	endfunction

	// colour stop followed by a stitch from the same byte
	function automatic row_exp_t exp_stop_one(input rec_kind_t k, input logic [15:0] dx,
			input logic [15:0] dy);
		row_exp_t e;
		e       = exp_none();
		e.n     = 2'd2;
		e.r0    = make_rec(REC_STOP, '0, '0, 1'b0);
		e.r1    = make_rec(k, dx, dy, 1'b1);
		return e;
	endfunction

	function automatic drow_t row(input in_word_t w, input row_exp_t e);
		drow_t d;
		d.w = w;
		d.e = e;
		return d;
	endfunction

	// Predictor: advance the decoder state by one word, queue its records if asked
	task automatic decode_word(input in_word_t w, input bit keep);
		out_word_t  r [2];
		int         n;
		logic [7:0] b;
		rec_kind_t  flag;
		bit         stitch;
		n = 0;
		b = w.data_byte;
		if (w.kind == KIND_LOAD) begin
			if (w.table_index < MAX_COLORS)
				tbl_count[w.table_index] = w.stitch_count;
			return;
		end
		case (ph)
			PH_SECOND: begin
				flag   = jump_on ? REC_JUMP : REC_NORMAL;
				stitch = 1'b1;
				ph     = PH_FIRST;
				// colour block complete: stop record comes first
				if (colour_idx < ncolors && colour_idx < MAX_COLORS &&
						pairs_since >= tbl_count[colour_idx[TBL_AW-1:0]]) begin
					r[n]        = make_rec(REC_STOP, '0, '0, 1'b0);
					n++;
					colour_idx  = colour_idx + 8'd1;
					pairs_since = '0;
				end
				if (held == ESC_BYTE) begin
					pairs_since = since_plus(pairs_since, 2'd1);
					if (b == ESC_SKIP) begin
						stitch = 1'b0;
					end else if (b == ESC_JUMP_OFF) begin
						jump_on = 1'b0;
						stitch  = 1'b0;
					end else if (b == ESC_TRIM) begin
						pairs_since = since_plus(pairs_since, 2'd2);
						jump_on     = 1'b1;
						long_acc    = '0;
						ph          = PH_LONG0;
						stitch      = 1'b0;
					end
				end
				// plain pair, or an unknown escape falling through
				if (stitch) begin
					pairs_since = since_plus(pairs_since, 2'd1);
					r[n]        = make_rec(flag, sx8(held), sx8(b), 1'b0);
					n++;
				end
			end
			PH_LONG0, PH_LONG1, PH_LONG2: begin
				long_acc = {long_acc[15:0], b};
				ph       = phase_t'(ph + 3'd1);
			end
			PH_LONG3: begin
				r[n] = make_rec(REC_TRIM, long_acc[23:8], {long_acc[7:0], b}, 1'b0);
				n++;
				ph   = PH_FIRST;
			end
			default: begin
				held = b;
				ph   = PH_SECOND;
			end
		endcase
		if (n > 0)
			r[n-1].last = 1'b1;
		if (keep) begin
			for (int i = 0; i < n; i++)
				pending_records.push_back(r[i]);
		end
	endtask

	task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%0t %s: want kind %0d dx %0d dy %0d last %0d, got kind %0d dx %0d dy %0d last %0d",
				$realtime, what, want.record_kind, $signed(want.delta_x), $signed(want.delta_y),
				want.last, got.record_kind, $signed(got.delta_x), $signed(got.delta_y), got.last);
	endtask

	// Scoreboard: check records against the oldest expectation, predict on accepted words
	always @(posedge clk) begin
		row_exp_t  e;
		out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_records.size() == 0) begin
					note_mismatch("record with nothing expected", '0, out_data);
				end else begin
					want = pending_records.pop_front();
					if (out_data.record_kind !== want.record_kind ||
							out_data.delta_x !== want.delta_x ||
							out_data.delta_y !== want.delta_y ||
							out_data.last !== want.last)
						note_mismatch("record mismatch", want, out_data);
				end
			end
			if (in_valid && !in_stall) begin
				e = row_exp_q.pop_front();
				decode_word(in_data, !e.typed);
				if (e.typed) begin
					if (e.n > 0)
						pending_records.push_back(e.r0);
					if (e.n > 1)
						pending_records.push_back(e.r1);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stall, or one long hold-off on request
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_WORDS) @(negedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// Offer one word after a random gap; returns once it is accepted
	task automatic send_word(input in_word_t w, input row_exp_t e);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_exp_q.push_back(e);
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(byte_w(b), BY_MODEL);
	endtask

	task automatic wait_drained();
		while (pending_records.size() != 0)
			@(negedge clk);
	endtask

	// Stop offering, let every record out and the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check(input logic [1:0] a, input logic [6:0] want);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got[6:0] !== want) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("%0t colour count read: want %0d, got %0d", $realtime, want, got[6:0]);
		end
	endtask

	task automatic set_colours(input logic [31:0] d);
		apb_write(ADDR_COLOR_COUNT, d);
		ncolors = d[6:0];
		apb_check(ADDR_COLOR_COUNT, d[6:0]);
	endtask

	// Random words: mostly well-formed pairs and escapes, some loads and stray bytes
	task automatic random_phase(input int n_words, input int pause_at, input bit do_hold);
		int          sent;
		int          r;
		int          k;
		logic [6:0]  idx;
		logic [31:0] cnt;
		bit          hold_sent;
		bit          paused;
		sent      = 0;
		hold_sent = 1'b0;
		paused    = 1'b0;
		while (sent < n_words) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// big counts only on high indexes so colours keep advancing
				k = $urandom_range(0, 99);
				if (k < 85) begin
					idx = 7'($urandom_range(0, 127));
					cnt = $urandom_range(0, 6);
				end else begin
					idx = 7'($urandom_range(100, 127));
					cnt = (k < 93) ? $urandom : 32'hFFFF_FFFF;
				end
				send_word(load_w(idx, cnt), BY_MODEL);
				sent += 1;
			end else if (r < 62) begin
				send_byte(8'($urandom));
				send_byte(8'($urandom));
				sent += 2;
			end else if (r < 72) begin
				send_byte(ESC_BYTE);
				send_byte(ESC_TRIM);
				repeat (4) send_byte(8'($urandom));
				sent += 6;
			end else if (r < 80) begin
				send_byte(ESC_BYTE);
				send_byte(ESC_JUMP_OFF);
				sent += 2;
			end else if (r < 87) begin
				send_byte(ESC_BYTE);
				send_byte(ESC_SKIP);
				sent += 2;
			end else if (r < 93) begin
				send_byte(ESC_BYTE);
				send_byte(8'($urandom));
				sent += 2;
			end else if (r < 97) begin
				// load slipped between the two bytes of a pair
				send_byte(8'($urandom));
				send_word(load_w(7'($urandom), $urandom_range(0, 6)), BY_MODEL);
				send_byte(8'($urandom));
				sent += 3;
			end else begin
				send_byte(8'($urandom));
				sent += 1;
			end
			if (do_hold && !hold_sent && sent >= 150) begin
				hold_sent    = 1'b1;
				hold_off_req = 1'b1;
			end
			if (pause_at > 0 && !paused && sent >= pause_at) begin
				paused = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				wait_drained();
			end
		end
	endtask

	// Main sequence
	initial begin
		logic [31:0] wd;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		hold_off_req = 1'b0;
		n_mismatch   = 0;
		ncolors      = '0;
		ph           = PH_FIRST;
		held         = '0;
		long_acc     = '0;
		jump_on      = 1'b0;
		colour_idx   = '0;
		pairs_since  = '0;
		snd_idle_pct = 37;
		rcv_idle_pct = 68;

		// entry 0 needs count 2, entry 1 the maximum; stops at the indexed lines
		dir_rows = '{
			row(load_w(7'd0, 32'd2), exp_none()),
			row(load_w(7'd1, 32'hFFFF_FFFF), exp_none()),
			row(load_w(7'd127, 32'd0), exp_none()),
			row(byte_w(8'h7F), exp_none()),
			row(byte_w(8'h80), exp_one(REC_NORMAL, 16'h007F, 16'hFF80)),
			row(byte_w(8'h00), exp_none()),
			row(byte_w(8'hFF), exp_one(REC_NORMAL, 16'h0000, 16'hFFFF)),
			row(byte_w(ESC_BYTE), exp_none()),
			row(byte_w(ESC_TRIM), exp_one(REC_STOP, 16'h0000, 16'h0000)),
			row(byte_w(8'h80), exp_none()),
			row(byte_w(8'h00), exp_none()),
			row(byte_w(8'h7F), exp_none()),
			row(byte_w(8'hFF), exp_one(REC_TRIM, 16'h8000, 16'h7FFF)),
			row(byte_w(8'h05), exp_none()),
			row(byte_w(8'hFB), exp_one(REC_JUMP, 16'h0005, 16'hFFFB)),
			row(byte_w(ESC_BYTE), exp_none()),
			row(byte_w(ESC_JUMP_OFF), exp_none()),
			row(byte_w(ESC_BYTE), exp_none()),
			row(byte_w(ESC_SKIP), exp_none()),
			row(byte_w(ESC_BYTE), exp_none()),
			row(byte_w(8'h80), BY_MODEL),
			row(byte_w(ESC_BYTE), exp_none()),
			row(byte_w(8'h7F), BY_MODEL),
			row(load_w(7'd1, 32'd0), exp_none()),
			row(byte_w(8'h01), exp_none()),
			row(byte_w(8'h01), exp_stop_one(REC_NORMAL, 16'h0001, 16'h0001)),
			row(byte_w(8'h02), exp_none()),
			row(byte_w(8'h02), exp_one(REC_NORMAL, 16'h0002, 16'h0002))
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// colour count after reset, then fill every table entry
		apb_check(ADDR_COLOR_COUNT, 7'd0);
		for (int i = 0; i < MAX_COLORS; i++)
			send_word(load_w(i[6:0], $urandom_range(0, 6)), BY_MODEL);
		settle();

		// directed rows with two colour blocks
		set_colours(32'd2);
		for (int i = 0; i < N_ROWS; i++)
			send_word(dir_rows[i].w, dir_rows[i].e);
		settle();

		// random: all colours, long receiver hold-off midway
		set_colours(32'd127);
		random_phase(400, 0, 1'b1);
		settle();

		// random: no colour stops, sender waits for the drain midway
		snd_idle_pct = 68;
		rcv_idle_pct = 37;
		set_colours(32'd0);
		random_phase(400, 150, 1'b0);
		settle();

		// random at full rate; upper data bits must be ignored
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		wd      = $urandom;
		wd[6:0] = 7'd127;
		set_colours(wd);
		random_phase(400, 0, 1'b0);
		settle();

		if (n_mismatch == 0 && pending_records.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
